FILE: src/ost_pkg.sv
package ost_pkg;

  // table geometry
  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);

  // item field widths
  localparam int MODE_W = 2;
  localparam int OBJ_W  = 16;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 16;
  localparam int ST_W   = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // request modes
  localparam logic [MODE_W-1:0] MODE_GET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_HIT      = 3'd0,
    ST_CLAIMED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_IDLE     = 3'd3,
    ST_HELD     = 3'd4,
    ST_RELEASED = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  // datapath actions selected by the control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_FETCH,
    ACT_SCAN,
    ACT_HIT,
    ACT_CLAIM,
    ACT_FULL,
    ACT_PUT_RD,
    ACT_PUT,
    ACT_IGNORE,
    ACT_CLEAR
  } act_t;

  // sequencer to datapath
  typedef struct packed {
    act_t act;
    logic rdy;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic              accept;
    logic [MODE_W-1:0] mode;
    logic              scan_done;
    logic              found;
    logic              no_free;
    logic              put_idle;
    logic              out_free;
  } flags_t;

endpackage

FILE: src/ost_in_if.sv
interface ost_in_if;
  import ost_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [OBJ_W-1:0]  object_number;
  logic [IDX_W-1:0]  slot_index;

  modport source (output valid, mode, object_number, slot_index, input ready);
  modport sink   (input valid, mode, object_number, slot_index, output ready);
endinterface

FILE: src/ost_out_if.sv
interface ost_out_if;
  import ost_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] slot_out;
  logic [OBJ_W-1:0] object_out;
  logic [CNT_W-1:0] count_out;

  modport source (output valid, status, slot_out, object_out, count_out, input ready);
  modport sink   (input valid, status, slot_out, object_out, count_out, output ready);
endinterface

FILE: src/refcounted_open_slot_table_unit.sv
// get: scan with one table slot compared per cycle, then hit, or claim or full on a miss;
//   a hit at slot k ends the scan at that slot
// put: live check and count read, then update; clear: resets all live bits
// one item in flight; the next item is accepted in the fetch step that follows the result step;
//   a waiting result holds the result step
// reset (synchronous, active low) clears all live bits directly, no clearing pass
module refcounted_open_slot_table_unit (
  input  logic      clk,
  input  logic      rst_n,
  ost_in_if.sink    in_chan,
  ost_out_if.source out_chan
);
  import ost_pkg::*;

  ctl_t   ctl;
  flags_t fl;

  // control store sequencer
  ost_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .fl    (fl),
    .ctl   (ctl)
  );

  // table datapath
  ost_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .ctl      (ctl),
    .fl       (fl)
  );

endmodule

FILE: src/ost_useq.sv
module ost_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  ost_pkg::flags_t fl,
  output ost_pkg::ctl_t   ctl
);
  import ost_pkg::*;

  typedef logic [3:0] upc_t;

  // program steps
  localparam upc_t U_FETCH   = 4'd0;
  localparam upc_t U_SCAN    = 4'd1;
  localparam upc_t U_DECIDE  = 4'd2;
  localparam upc_t U_MISS    = 4'd3;
  localparam upc_t U_CLAIM   = 4'd4;
  localparam upc_t U_HIT     = 4'd5;
  localparam upc_t U_FULL    = 4'd6;
  localparam upc_t U_PUT_CHK = 4'd7;
  localparam upc_t U_PUT_UPD = 4'd8;
  localparam upc_t U_PUT_IGN = 4'd9;
  localparam upc_t U_CLEAR   = 4'd10;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_SCAN_DONE,
    C_FOUND,
    C_NO_FREE,
    C_PUT_IDLE
  } cond_t;

  typedef struct packed {
    cond_t cond;
    upc_t  tgt;
    logic  stay;
    act_t  act;
    logic  emit;
    logic  rdy;
  } uword_t;

  // control store
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '{cond: C_ALWAYS, tgt: U_FETCH, stay: 1'b0, act: ACT_NONE, emit: 1'b0, rdy: 1'b0};
    unique case (a)
      U_FETCH:   w = '{cond: C_DISPATCH, tgt: U_FETCH, stay: 1'b1, act: ACT_FETCH,
                       emit: 1'b0, rdy: 1'b1};
      U_SCAN:    w = '{cond: C_SCAN_DONE, tgt: U_DECIDE, stay: 1'b1, act: ACT_SCAN,
                       emit: 1'b0, rdy: 1'b0};
      U_DECIDE:  w = '{cond: C_FOUND, tgt: U_HIT, stay: 1'b0, act: ACT_NONE,
                       emit: 1'b0, rdy: 1'b0};
      U_MISS:    w = '{cond: C_NO_FREE, tgt: U_FULL, stay: 1'b0, act: ACT_NONE,
                       emit: 1'b0, rdy: 1'b0};
      U_CLAIM:   w = '{cond: C_ALWAYS, tgt: U_FETCH, stay: 1'b0, act: ACT_CLAIM,
                       emit: 1'b1, rdy: 1'b0};
      U_HIT:     w = '{cond: C_ALWAYS, tgt: U_FETCH, stay: 1'b0, act: ACT_HIT,
                       emit: 1'b1, rdy: 1'b0};
      U_FULL:    w = '{cond: C_ALWAYS, tgt: U_FETCH, stay: 1'b0, act: ACT_FULL,
                       emit: 1'b1, rdy: 1'b0};
      U_PUT_CHK: w = '{cond: C_PUT_IDLE, tgt: U_PUT_IGN, stay: 1'b0, act: ACT_PUT_RD,
                       emit: 1'b0, rdy: 1'b0};
      U_PUT_UPD: w = '{cond: C_ALWAYS, tgt: U_FETCH, stay: 1'b0, act: ACT_PUT,
                       emit: 1'b1, rdy: 1'b0};
      U_PUT_IGN: w = '{cond: C_ALWAYS, tgt: U_FETCH, stay: 1'b0, act: ACT_IGNORE,
                       emit: 1'b1, rdy: 1'b0};
      U_CLEAR:   w = '{cond: C_ALWAYS, tgt: U_FETCH, stay: 1'b0, act: ACT_CLEAR,
                       emit: 1'b1, rdy: 1'b0};
      default:   w = '{cond: C_ALWAYS, tgt: U_FETCH, stay: 1'b0, act: ACT_NONE,
                       emit: 1'b0, rdy: 1'b0};
    endcase
    return w;
  endfunction

  // entry point per request mode
  function automatic upc_t dispatch(input logic [MODE_W-1:0] m);
    upc_t t;
    t = U_FETCH;
    unique case (m)
      MODE_GET:   t = U_SCAN;
      MODE_PUT:   t = U_PUT_CHK;
      MODE_CLEAR: t = U_CLEAR;
      default:    t = U_FETCH;
    endcase
    return t;
  endfunction

  upc_t   upc_r, upc_nxt;
  uword_t uw;
  logic   go;
  logic   cond_true;

  // step sequencing
  always_comb begin
    uw = ucode(upc_r);
    go = (!uw.emit || fl.out_free) && (!uw.rdy || fl.accept);
    unique case (uw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_DISPATCH:  cond_true = 1'b1;
      C_SCAN_DONE: cond_true = fl.scan_done;
      C_FOUND:     cond_true = fl.found;
      C_NO_FREE:   cond_true = fl.no_free;
      C_PUT_IDLE:  cond_true = fl.put_idle;
      default:     cond_true = 1'b0;
    endcase
    if (!go) begin
      upc_nxt = upc_r;
    end else if (uw.cond == C_DISPATCH) begin
      upc_nxt = dispatch(fl.mode);
    end else if (cond_true) begin
      upc_nxt = uw.tgt;
    end else if (uw.stay) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + 4'd1;
    end
    ctl.act = go ? uw.act : ACT_NONE;
    ctl.rdy = uw.rdy;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: src/ost_dpath.sv
module ost_dpath (
  input  logic            clk,
  input  logic            rst_n,
  ost_in_if.sink          in_chan,
  ost_out_if.source       out_chan,
  input  ost_pkg::ctl_t   ctl,
  output ost_pkg::flags_t fl
);
  import ost_pkg::*;

  // tables: live bits in flops, object numbers and counts in memories
  logic [SLOTS-1:0] live_r;
  logic [OBJ_W-1:0] obj_mem [SLOTS];
  logic [CNT_W-1:0] cnt_mem [SLOTS];

  // latched item
  logic [OBJ_W-1:0] obj_r;
  logic [IDX_W-1:0] slot_in_r;

  // scan pipeline
  slot_t            idx_r, idx_d_r, free_slot_r, sel_slot_r;
  logic             cmp_vld_r, last_d_r, live_d_r, have_free_r, found_r;
  logic [OBJ_W-1:0] obj_rd_r;
  logic [CNT_W-1:0] cnt_rd_r, sel_cnt_r;

  // result register
  logic             out_valid_r;
  status_t          status_r;
  logic [IDX_W-1:0] slot_out_r;
  logic [OBJ_W-1:0] object_out_r;
  logic [CNT_W-1:0] count_out_r;

  slot_t            put_idx, rd_addr, cnt_wa;
  logic             put_range, put_live;
  logic             hit_now, free_now, scan_done;
  logic             cnt_we, obj_we, emit;
  logic [CNT_W-1:0] cnt_inc, cnt_dec, cnt_wd;

  // compare stage and put decode
  always_comb begin
    put_idx   = slot_t'(slot_in_r);
    put_range = 32'(slot_in_r) < SLOTS;
    put_live  = put_range && live_r[put_idx];
    hit_now   = cmp_vld_r && live_d_r && (obj_rd_r == obj_r);
    free_now  = cmp_vld_r && !live_d_r && !have_free_r;
    scan_done = cmp_vld_r && (hit_now || last_d_r);
    rd_addr   = (ctl.act == ACT_PUT_RD) ? put_idx : idx_r;
    cnt_inc   = (sel_cnt_r == COUNT_MAX) ? sel_cnt_r : sel_cnt_r + CNT_W'(1);
    cnt_dec   = cnt_rd_r - CNT_W'(1);
  end

  // count and object write port
  always_comb begin
    cnt_we = 1'b0;
    obj_we = 1'b0;
    cnt_wa = sel_slot_r;
    cnt_wd = cnt_inc;
    unique case (ctl.act)
      ACT_HIT: begin
        cnt_we = 1'b1;
      end
      ACT_CLAIM: begin
        cnt_we = 1'b1;
        obj_we = 1'b1;
        cnt_wd = CNT_W'(1);
      end
      ACT_PUT: begin
        cnt_we = 1'b1;
        cnt_wa = put_idx;
        cnt_wd = cnt_dec;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
    emit = (ctl.act == ACT_HIT) || (ctl.act == ACT_CLAIM) || (ctl.act == ACT_FULL) ||
           (ctl.act == ACT_PUT) || (ctl.act == ACT_IGNORE) || (ctl.act == ACT_CLEAR);
  end

  // memories, registered read held outside scan and put read steps
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (obj_we) begin
      obj_mem[sel_slot_r] <= obj_r;
    end
    if (ctl.act == ACT_SCAN || ctl.act == ACT_PUT_RD) begin
      obj_rd_r <= obj_mem[rd_addr];
      cnt_rd_r <= cnt_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      cmp_vld_r <= (ctl.act == ACT_SCAN);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.act == ACT_CLEAR) begin
        live_r <= '0;
      end else if (ctl.act == ACT_CLAIM) begin
        live_r[sel_slot_r] <= 1'b1;
      end else if (ctl.act == ACT_PUT && cnt_dec == '0) begin
        live_r[put_idx] <= 1'b0;
      end
    end
  end

  // item latch and scan registers
  always_ff @(posedge clk) begin
    if (ctl.act == ACT_FETCH) begin
      obj_r       <= in_chan.object_number;
      slot_in_r   <= in_chan.slot_index;
      idx_r       <= '0;
      have_free_r <= 1'b0;
    end
    if (ctl.act == ACT_SCAN) begin
      idx_d_r  <= idx_r;
      last_d_r <= (32'(idx_r) == SLOTS - 1);
      live_d_r <= live_r[idx_r];
      if (32'(idx_r) != SLOTS - 1) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
      if (free_now) begin
        have_free_r <= 1'b1;
        free_slot_r <= idx_d_r;
      end
      if (scan_done) begin
        found_r    <= hit_now;
        sel_cnt_r  <= cnt_rd_r;
        sel_slot_r <= hit_now ? idx_d_r : (free_now ? idx_d_r : free_slot_r);
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    unique case (ctl.act)
      ACT_HIT: begin
        status_r     <= ST_HIT;
        slot_out_r   <= IDX_W'(sel_slot_r);
        object_out_r <= obj_r;
        count_out_r  <= cnt_inc;
      end
      ACT_CLAIM: begin
        status_r     <= ST_CLAIMED;
        slot_out_r   <= IDX_W'(sel_slot_r);
        object_out_r <= obj_r;
        count_out_r  <= CNT_W'(1);
      end
      ACT_FULL: begin
        status_r     <= ST_FULL;
        slot_out_r   <= '0;
        object_out_r <= obj_r;
        count_out_r  <= '0;
      end
      ACT_PUT: begin
        slot_out_r <= slot_in_r;
        if (cnt_dec == '0) begin
          status_r     <= ST_RELEASED;
          object_out_r <= obj_rd_r;
          count_out_r  <= '0;
        end else begin
          status_r     <= ST_HELD;
          object_out_r <= '0;
          count_out_r  <= cnt_dec;
        end
      end
      ACT_IGNORE: begin
        status_r     <= ST_IDLE;
        slot_out_r   <= slot_in_r;
        object_out_r <= '0;
        count_out_r  <= '0;
      end
      ACT_CLEAR: begin
        status_r     <= ST_CLEARED;
        slot_out_r   <= '0;
        object_out_r <= '0;
        count_out_r  <= '0;
      end
      default: begin
        status_r <= status_r;
      end
    endcase
  end

  // ports and flags
  assign in_chan.ready       = ctl.rdy;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = status_r;
  assign out_chan.slot_out   = slot_out_r;
  assign out_chan.object_out = object_out_r;
  assign out_chan.count_out  = count_out_r;

  assign fl.accept    = in_chan.valid && ctl.rdy;
  assign fl.mode      = in_chan.mode;
  assign fl.scan_done = scan_done;
  assign fl.found     = found_r;
  assign fl.no_free   = !have_free_r;
  assign fl.put_idle  = !put_live;
  assign fl.out_free  = !out_valid_r || out_chan.ready;

`ifndef SYNTHESIS
  // a claim takes a slot that was free
  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.act == ACT_CLAIM |-> !live_r[sel_slot_r])
    else $error("claim on a live slot");

  // a hit updates a live slot
  a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.act == ACT_HIT |-> live_r[sel_slot_r])
    else $error("hit on a free slot");

  // a release only touches a live slot
  a_put_live: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.act == ACT_PUT |-> put_live)
    else $error("put update on a free slot");

  // clear empties the table
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.act == ACT_CLEAR |=> live_r == '0)
    else $error("table not empty after clear");

  // a result is never written over one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(status_r))
    else $error("pending item overwritten");
`endif

endmodule
